// File: hw/rtl/lob_pkg.sv
// package for the limit order book: codes, types and defaults
package lob_pkg;

    localparam int ORDER_SLOTS_DEF  = 256;
    localparam int SYMBOL_COUNT_DEF = 16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_DUP      = 2'd3;

    // one stored order, as packed into the slot memory
    typedef struct packed {
        logic [31:0] order_id;
        logic [3:0]  symbol;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [31:0] arrival;
    } t_slot;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] order_id;
        logic [3:0]  symbol;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] order_id_out;
        logic [3:0]  symbol_out;
        logic        side_out;
        logic [31:0] price_out;
        logic [31:0] quantity_out;
    } t_rsp;

endpackage

// File: hw/rtl/lob_if.sv
// valid/ready channel interfaces for requests and responses
interface lob_req_if;
    import lob_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lob_rsp_if;
    import lob_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/lob_ram.sv
// generic single port ram with registered read
module lob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: hw/rtl/lob_cmp.sv
// shared compare unit: id match, symbol and side filter and price-time ranking
module lob_cmp (
    input  lob_pkg::t_slot i_slot,
    input  logic           i_valid,
    input  logic [31:0]    i_key_id,
    input  logic [3:0]     i_key_sym,
    input  logic           i_key_side,
    input  logic           i_have,
    input  logic [31:0]    i_best_price,
    input  logic [31:0]    i_best_age,
    input  logic [31:0]    i_now,
    output logic           o_id_hit,
    output logic           o_better,
    output logic [31:0]    o_age
);
    import lob_pkg::*;
    logic match;
    logic better_price;

    // match and rank the slot against the running best
    always_comb begin
        o_age        = i_now - i_slot.arrival;
        o_id_hit     = i_valid && (i_slot.order_id == i_key_id);
        match        = i_valid && (i_slot.symbol == i_key_sym) && (i_slot.side == i_key_side);
        better_price = i_key_side ? (i_slot.price < i_best_price)
                                  : (i_slot.price > i_best_price);
        o_better     = match && (!i_have || better_price ||
                       ((i_slot.price == i_best_price) && (o_age > i_best_age)));
    end
endmodule

// File: hw/rtl/limit_order_book.sv
// limit order book top level: slot scan sequencer over a slot memory
//
//  channel   dir  handshake      payload
//  req       in   valid/ready    opcode order_id symbol side price quantity
//  rsp       out  valid/ready    status order_id_out symbol_out side_out price_out quantity_out
//
// every request scans all ORDER_SLOTS slots through one registered memory
// read port and one compare unit, then passes write back (S_DONE), two read
// states (S_RD, S_RDW) and the response load (S_OUT), the same for every opcode.
// the response turns valid in the same cycle that ready returns, so a new
// request is taken only once the previous response has been loaded.
// a pending response does not block acceptance; the response load waits in
// S_OUT for as long as the previous response stays unaccepted.
// slot valid bits sit in flip-flops and clear at reset; no clearing pass.
module limit_order_book #(
    parameter int ORDER_SLOTS  = lob_pkg::ORDER_SLOTS_DEF,
    parameter int SYMBOL_COUNT = lob_pkg::SYMBOL_COUNT_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    lob_req_if.sink   i_req,
    lob_rsp_if.source o_rsp
);
    import lob_pkg::*;

    localparam int AW = $clog2(ORDER_SLOTS);
    localparam logic [AW:0] SCAN_END = (AW+1)'(ORDER_SLOTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DONE  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_RDW   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  r_state, n_state;
    t_req        r_req;
    logic [AW:0] r_addr;     // issue counter
    logic [AW-1:0] r_cmp_addr;
    logic        r_cmp_v;
    logic [ORDER_SLOTS-1:0] r_valid;
    logic [31:0] r_now;
    logic        r_found, r_have, r_free_have;
    logic [AW-1:0] r_hit, r_best, r_free;
    logic [31:0] r_best_price, r_best_age;
    logic        r_rsp_v;
    t_rsp        r_rsp, n_rsp;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    t_slot         ram_wdata, ram_rdata;
    logic          id_hit, better;
    logic [31:0]   age;
    logic          sym_bad;
    logic          rsp_load;

    assign sym_bad = ({5'd0, r_req.symbol} >= 9'(SYMBOL_COUNT));

    lob_ram #(.WIDTH($bits(t_slot)), .DEPTH(ORDER_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    lob_cmp u_cmp (
        .i_slot       (ram_rdata),
        .i_valid      (r_cmp_v && r_valid[r_cmp_addr]),
        .i_key_id     (r_req.order_id),
        .i_key_sym    (r_req.symbol),
        .i_key_side   (r_req.side),
        .i_have       (r_have),
        .i_best_price (r_best_price),
        .i_best_age   (r_best_age),
        .i_now        (r_now),
        .o_id_hit     (id_hit),
        .o_better     (better),
        .o_age        (age)
    );

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_rsp_v;
    assign o_rsp.payload = r_rsp;

    // response register loads once the previous response is gone or leaving
    assign rsp_load = (r_state == S_OUT) && (!r_rsp_v || o_rsp.ready);

    // memory address and write data
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_addr[AW-1:0];
        ram_wdata = '{order_id: r_req.order_id, symbol: r_req.symbol, side: r_req.side,
                      price: r_req.price, quantity: r_req.quantity, arrival: r_now};
        if (r_state == S_DONE || r_state == S_RD || r_state == S_RDW ||
            r_state == S_OUT) begin
            ram_addr = (r_req.opcode == OP_CANCEL) ? r_hit : r_best;
            if (r_req.opcode == OP_ADD) begin
                ram_addr = r_free;
                ram_we   = (r_state == S_DONE) && !sym_bad && !r_found && r_free_have;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req.valid && i_req.ready) n_state = S_SCAN;
            S_SCAN:  if (!r_cmp_v && r_addr == SCAN_END) n_state = S_DONE;
            S_DONE:  n_state = S_RD;
            S_RD:    n_state = S_RDW;
            S_RDW:   n_state = S_OUT;
            S_OUT:   if (rsp_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_now   <= '0;
            r_rsp_v <= 1'b0;
            r_cmp_v <= 1'b0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            if (rsp_load) r_rsp_v <= 1'b1;
            else if (o_rsp.valid && o_rsp.ready) r_rsp_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_addr  <= '0;
                    r_cmp_v <= 1'b0;
                end
                S_SCAN: begin
                    r_cmp_v <= (r_addr != SCAN_END);
                    if (r_addr != SCAN_END) r_addr <= r_addr + (AW+1)'(1);
                end
                S_DONE: begin
                    r_cmp_v <= 1'b0;
                    if (ram_we) begin
                        r_valid[r_free] <= 1'b1;
                        r_now <= r_now + 32'd1;
                    end
                    if (r_req.opcode == OP_CANCEL && r_found) r_valid[r_hit] <= 1'b0;
                    if (r_req.opcode == OP_REMOVE && !sym_bad && r_have)
                        r_valid[r_best] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // response contents from the request and the slot read back
    always_comb begin
        n_rsp = '0;
        priority if (r_req.opcode == OP_CANCEL) begin
            if (r_found) n_rsp = {ST_OK, ram_rdata.order_id, ram_rdata.symbol,
                                  ram_rdata.side, ram_rdata.price, ram_rdata.quantity};
            else n_rsp.status = ST_NOTFOUND;
        end else if (sym_bad) begin
            n_rsp.status = ST_NOTFOUND;
        end else if (r_req.opcode == OP_ADD) begin
            if (r_found) n_rsp.status = ST_DUP;
            else if (!r_free_have) n_rsp.status = ST_FULL;
            else n_rsp = {ST_OK, r_req.order_id, r_req.symbol, r_req.side,
                          r_req.price, r_req.quantity};
        end else begin
            if (r_have) n_rsp = {ST_OK, ram_rdata.order_id, ram_rdata.symbol,
                                 ram_rdata.side, ram_rdata.price, ram_rdata.quantity};
            else n_rsp.status = ST_NOTFOUND;
        end
    end

    // scan bookkeeping and response register, payload only
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_req       <= i_req.payload;
            r_found     <= 1'b0;
            r_have      <= 1'b0;
            r_free_have <= 1'b0;
            r_hit       <= '0;
            r_best      <= '0;
            r_free      <= '0;
            r_best_price <= '0;
            r_best_age   <= '0;
        end
        if (r_state == S_SCAN) begin
            r_cmp_addr <= r_addr[AW-1:0];
            if (r_cmp_v) begin
                if (id_hit && !r_found) begin
                    r_found <= 1'b1;
                    r_hit   <= r_cmp_addr;
                end
                if (better) begin
                    r_have       <= 1'b1;
                    r_best       <= r_cmp_addr;
                    r_best_price <= ram_rdata.price;
                    r_best_age   <= age;
                end
                if (!r_valid[r_cmp_addr] && !r_free_have) begin
                    r_free_have <= 1'b1;
                    r_free      <= r_cmp_addr;
                end
            end
        end
        if (rsp_load) r_rsp <= n_rsp;
    end

    // response register holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_v && !o_rsp.ready |=> r_rsp_v && $stable(r_rsp))
        else $error("response dropped while stalled");
    // no request taken while a scan runs
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_req.ready)
        else $error("ready during scan");
    // arrival count moves only on a stored add
    a_now: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_DONE |=> $stable(r_now))
        else $error("arrival counter moved outside write back");
endmodule

// File: verif/limit_order_book_tb.sv
// self-checking testbench for the limit order book: directed table, store fill and drain, then random traffic
module limit_order_book_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lob_pkg::*;

    localparam int SLOTS   = ORDER_SLOTS_DEF;
    localparam int SYMBOLS = SYMBOL_COUNT_DEF;
    localparam int NUM_RANDOM = 1012;
    localparam int EXP_DEPTH = 16;
    localparam longint CYCLE_LIMIT = 4000000;

    logic i_clk;
    logic i_rst_n;
    lob_req_if req_ch();
    lob_rsp_if rsp_ch();

    limit_order_book dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // book shadow state
    bit          book_live[SLOTS];
    logic [31:0] book_id[SLOTS];
    logic [3:0]  book_sym[SLOTS];
    logic        book_side[SLOTS];
    logic [31:0] book_price[SLOTS];
    logic [31:0] book_qty[SLOTS];
    logic [31:0] book_arrival[SLOTS];
    logic [31:0] arrival_count;

    // expected responses in request order
    t_rsp exp_store[EXP_DEPTH];
    int   exp_wr;
    int   exp_rd;
    int   error_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;
    longint cycle_count;

    function automatic t_rsp slot_rsp(int s);
        t_rsp r;
        r.status = ST_OK;
        r.order_id_out = book_id[s];
        r.symbol_out = book_sym[s];
        r.side_out = book_side[s];
        r.price_out = book_price[s];
        r.quantity_out = book_qty[s];
        return r;
    endfunction

    function automatic t_rsp miss_rsp(logic [1:0] code);
        t_rsp r;
        r = '0;
        r.status = code;
        return r;
    endfunction

    function automatic int find_order(logic [31:0] id);
        for (int s = 0; s < SLOTS; s++)
            if (book_live[s] && book_id[s] == id) return s;
        return -1;
    endfunction

    // price-time priority search
    function automatic int find_top(logic [3:0] sym, logic side);
        int best;
        logic [31:0] age, best_age;
        best = -1;
        for (int s = 0; s < SLOTS; s++) begin
            if (!book_live[s] || book_sym[s] != sym || book_side[s] != side) continue;
            if (best < 0) begin
                best = s;
                continue;
            end
            if (side ? (book_price[s] < book_price[best])
                     : (book_price[s] > book_price[best])) begin
                best = s;
            end else if (book_price[s] == book_price[best]) begin
                age = arrival_count - book_arrival[s];
                best_age = arrival_count - book_arrival[best];
                if (age > best_age) best = s;
            end
        end
        return best;
    endfunction

    // apply one request to the shadow book and return the response it yields
    function automatic t_rsp book_update(t_req q);
        int s;
        t_rsp r;
        if (q.opcode == OP_CANCEL) begin
            s = find_order(q.order_id);
            if (s < 0) return miss_rsp(ST_NOTFOUND);
            r = slot_rsp(s);
            book_live[s] = 1'b0;
            return r;
        end
        if (q.symbol >= SYMBOLS) return miss_rsp(ST_NOTFOUND);
        if (q.opcode == OP_ADD) begin
            if (find_order(q.order_id) >= 0) return miss_rsp(ST_DUP);
            s = -1;
            for (int k = 0; k < SLOTS; k++)
                if (!book_live[k]) begin
                    s = k;
                    break;
                end
            if (s < 0) return miss_rsp(ST_FULL);
            book_live[s] = 1'b1;
            book_id[s] = q.order_id;
            book_sym[s] = q.symbol;
            book_side[s] = q.side;
            book_price[s] = q.price;
            book_qty[s] = q.quantity;
            book_arrival[s] = arrival_count;
            arrival_count = arrival_count + 1;
            return slot_rsp(s);
        end
        s = find_top(q.symbol, q.side);
        if (s < 0) return miss_rsp(ST_NOTFOUND);
        r = slot_rsp(s);
        if (q.opcode == OP_REMOVE) book_live[s] = 1'b0;
        return r;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        foreach (book_live[s]) n += book_live[s];
        return n;
    endfunction

    // send one request and record its expected response; valid stays up
    // between back to back requests and drops only while idling
    task automatic send_req(t_req q, bit fixed_exp, t_rsp fixed_rsp);
        t_rsp r;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        req_ch.payload <= q;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        r = book_update(q);
        if (fixed_exp && r != fixed_rsp)
            $display("%0t table row disagrees with book: exp %h calc %h",
                     $time, fixed_rsp, r);
        exp_store[exp_wr % EXP_DEPTH] = fixed_exp ? fixed_rsp : r;
        exp_wr++;
    endtask

    function automatic t_req make_req(logic [1:0] op, logic [31:0] id, logic [3:0] sym,
                                      logic side, logic [31:0] pr, logic [31:0] qty);
        t_req q;
        q.opcode = op;
        q.order_id = id;
        q.symbol = sym;
        q.side = side;
        q.price = pr;
        q.quantity = qty;
        return q;
    endfunction

    // directed table
    typedef struct {
        t_req q;
        bit   fixed;
        t_rsp r;
    } t_row;

    t_row dir_rows[32];
    int   dir_count;

    function automatic void add_row(t_req q, bit fixed, t_rsp r);
        dir_rows[dir_count] = '{q, fixed, r};
        dir_count++;
    endfunction

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    // response sink with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= !hold_off && !(recv_stall_pct > 0 &&
                                          $urandom_range(99) < recv_stall_pct);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (exp_wr == exp_rd) begin
                    $display("%0t unexpected response: exp none act %h",
                             $time, rsp_ch.payload);
                    error_count++;
                end else begin
                    t_rsp e;
                    e = exp_store[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (rsp_ch.payload.status !== e.status ||
                        rsp_ch.payload.order_id_out !== e.order_id_out ||
                        rsp_ch.payload.symbol_out !== e.symbol_out ||
                        rsp_ch.payload.side_out !== e.side_out ||
                        rsp_ch.payload.price_out !== e.price_out ||
                        rsp_ch.payload.quantity_out !== e.quantity_out) begin
                        $display("%0t response mismatch: exp %h act %h",
                                 $time, e, rsp_ch.payload);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    task automatic hold_responses(int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    function automatic t_req random_req(int id_pool);
        t_req q;
        int pick;
        q.order_id = (id_pool > 0) ? $urandom_range(id_pool - 1) : $urandom;
        q.symbol = ($urandom_range(19) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(3));
        q.side = 1'($urandom_range(1));
        q.price = ($urandom_range(9) == 0) ? $urandom : 1000 + $urandom_range(15);
        q.quantity = $urandom;
        pick = $urandom_range(99);
        if (pick < 45) q.opcode = OP_ADD;
        else if (pick < 60) q.opcode = OP_CANCEL;
        else if (pick < 80) q.opcode = OP_QUERY;
        else q.opcode = OP_REMOVE;
        return q;
    endfunction

    initial begin
        t_rsp none;
        t_req q;
        int pool;
        none = '0;
        error_count = 0;
        cycle_count = 0;
        exp_wr = 0;
        exp_rd = 0;
        dir_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        arrival_count = '0;
        foreach (book_live[s]) book_live[s] = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty book, unknown id, extremes, duplicates, ties
        add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0), 1, miss_rsp(ST_NOTFOUND));
        add_row(make_req(OP_REMOVE, 0, 15, 1, 0, 0), 1, miss_rsp(ST_NOTFOUND));
        add_row(make_req(OP_CANCEL, 32'hFFFFFFFF, 0, 0, 0, 0), 1,
                miss_rsp(ST_NOTFOUND));
        add_row(make_req(OP_ADD, 32'hFFFFFFFF, 15, 1, 32'hFFFFFFFF,
                         32'hFFFFFFFF), 0, none);
        add_row(make_req(OP_ADD, 32'hFFFFFFFF, 1, 0, 5, 5), 1, miss_rsp(ST_DUP));
        add_row(make_req(OP_ADD, 1, 0, 0, 0, 0), 0, none);
        add_row(make_req(OP_ADD, 2, 0, 0, 100, 7), 0, none);
        add_row(make_req(OP_ADD, 3, 0, 0, 100, 8), 0, none);
        add_row(make_req(OP_ADD, 4, 0, 1, 100, 9), 0, none);
        add_row(make_req(OP_ADD, 5, 0, 1, 50, 10), 0, none);
        add_row(make_req(OP_ADD, 6, 0, 1, 50, 11), 0, none);
        add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(OP_QUERY, 0, 0, 1, 0, 0), 0, none);
        add_row(make_req(OP_REMOVE, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(OP_REMOVE, 0, 0, 1, 0, 0), 0, none);
        add_row(make_req(OP_CANCEL, 2, 0, 0, 0, 0), 1, miss_rsp(ST_NOTFOUND));
        add_row(make_req(OP_CANCEL, 3, 0, 0, 0, 0), 0, none);
        add_row(make_req(OP_QUERY, 0, 15, 1, 0, 0), 0, none);
        add_row(make_req(OP_CANCEL, 32'hFFFFFFFF, 0, 0, 0, 0), 0, none);
        add_row(make_req(OP_ADD, 0, 0, 1, 32'hAAAAAAAA, 32'h55555555), 0, none);
        add_row(make_req(OP_QUERY, 32'h12345678, 0, 1, 1, 1), 0, none);
        for (int i = 0; i < dir_count; i++)
            send_req(dir_rows[i].q, dir_rows[i].fixed, dir_rows[i].r);
        wait_drained();

        // fill the store, then hit store full
        while (live_count() < SLOTS)
            send_req(make_req(OP_ADD, 32'h8000_0000 + $urandom_range(65535),
                              4'($urandom_range(15)), 1'($urandom_range(1)),
                              $urandom_range(40), $urandom), 0, none);
        send_req(make_req(OP_ADD, 32'h0000_7777, 2, 0, 1, 1), 1, miss_rsp(ST_FULL));
        // drain partially via removes, with a long receiver hold-off
        fork
            hold_responses(3000);
        join_none
        repeat (64) send_req(make_req(OP_REMOVE, 0, 4'($urandom_range(15)),
                                      1'($urandom_range(1)), 0, 0), 0, none);
        wait_drained();
        repeat (200) send_req(make_req(OP_CANCEL, 32'h8000_0000 + $urandom_range(65535),
                                       0, 0, 0, 0), 0, none);

        // random phases, the first three over a small id pool so cancels and duplicates hit
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            pool = (ph == 3) ? 0 : 300;
            for (int i = 0; i < NUM_RANDOM / 4; i++) begin
                q = random_req(pool);
                send_req(q, 0, none);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        wait_drained();
        repeat (SLOTS + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
